// File: rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg: shared types and constants of the disk seek distance calculator
// Holds the policy codes, the sequencer states, the search windows and the
// result bundle of the shared distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dss_pkg;

    // Width and ceiling of the saturating movement total.
    localparam int              TOTAL_W   = 24;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Width of the policy register.
    localparam int POLICY_W = 2;

    // Scheduling policies.
    typedef enum logic [POLICY_W-1:0] {
        POL_FCFS  = 2'd0,
        POL_SSTF  = 2'd1,
        POL_SCAN  = 2'd2,
        POL_CSCAN = 2'd3
    } t_policy;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_LOAD,
        S_PREP,
        S_FCFS,
        S_SCANP,
        S_MARK,
        S_ZERO,
        S_OUT
    } t_state;

    // Window of cylinders that a nearest-first pass may pick from.
    typedef enum logic [1:0] {
        WIN_ALL,
        WIN_BELOW,
        WIN_ATLEAST
    } t_window;

    // Result of the shared distance unit.
    typedef struct packed {
        logic [TOTAL_W-1:0] sum;
        logic               sat;
        logic               lt;
    } t_alu_res;

endpackage

`default_nettype wire

// File: rtl/dss_mem.sv
// ----------------------------------------------------------------------------
// dss_mem: request store
// One write port and one registered read port. Each word holds a served
// mark above the requested cylinder.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/dss_alu.sv
// ----------------------------------------------------------------------------
// dss_alu: shared distance unit
// Forms the distance between two cylinders, compares it with the best
// distance so far and adds it to the running total with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_alu import dss_pkg::*; #(
    parameter int CW = 16
) (
    input  wire logic [CW-1:0]      i_a,
    input  wire logic [CW-1:0]      i_b,
    input  wire logic [CW-1:0]      i_best,
    input  wire logic [TOTAL_W-1:0] i_total,
    output logic      [CW-1:0]      o_dist,
    output t_alu_res                o_res
);

    logic [CW-1:0]    seek_d;
    logic [TOTAL_W:0] sum_w;

    // Absolute difference, then the saturating sum and the compare.
    always_comb begin
        seek_d    = (i_a > i_b) ? (i_a - i_b) : (i_b - i_a);
        o_dist    = seek_d;
        sum_w     = {1'b0, i_total} + (TOTAL_W + 1)'(seek_d);
        o_res.sat = sum_w[TOTAL_W];
        o_res.sum = sum_w[TOTAL_W] ? TOTAL_MAX : sum_w[TOTAL_W-1:0];
        o_res.lt  = (seek_d < i_best);
    end

endmodule

`default_nettype wire

// File: rtl/disk_seek_schedule_distance.sv
// Loading takes one item per cycle; after the closing item the input stalls until the
// result is registered, also waiting for the output register to be free. Each pass reads
// the stored requests through the single read port into one distance unit; every served
// request costs one pass and one visit to the mark state.
// Reset (synchronous, active low) clears the set, the policy and the output valid.
// ----------------------------------------------------------------------------
// disk_seek_schedule_distance: disk head movement calculator
// Stores a head position and a set of cylinder requests, then walks them under
// the chosen scheduling policy with one shared distance unit and reports the
// saturated total head movement.
// ----------------------------------------------------------------------------
`default_nettype none

module disk_seek_schedule_distance import dss_pkg::*; #(
    parameter int MAX_REQUESTS  = 64,
    parameter int CYLINDER_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [15:0]         i_cylinder,
    input  wire logic                i_last_request,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [TOTAL_W-1:0]       o_total_movement,
    output logic                     o_overflow,
    input  wire logic                i_policy_we,
    input  wire logic [POLICY_W-1:0] i_policy
);

    localparam int CW   = (CYLINDER_BITS < 16) ? CYLINDER_BITS : 16;
    localparam int AW   = (MAX_REQUESTS > 2) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNTW = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_REQUESTS);

    t_state             r_state, n_state;
    t_policy            r_policy;
    t_policy            r_run_pol, n_run_pol;
    t_window            r_win, n_win;
    logic [CW-1:0]      r_head, n_head;
    logic               r_head_ld, n_head_ld;
    logic [CNTW-1:0]    r_cnt, n_cnt;
    logic               r_drop, n_drop;
    logic [CW-1:0]      r_pos, n_pos;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic               r_sat, n_sat;
    logic [CNTW-1:0]    r_idx, n_idx;
    logic               r_rdv, n_rdv;
    logic [AW-1:0]      r_ridx;
    logic               r_found, n_found;
    logic [CW-1:0]      r_bestd, n_bestd;
    logic [AW-1:0]      r_bestidx, n_bestidx;
    logic [CW-1:0]      r_bestval, n_bestval;
    logic               r_step, n_step;
    logic               r_ovalid, n_ovalid;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;
    logic               r_out_ovf, n_out_ovf;

    logic               in_xfer;
    logic [CW-1:0]      cyl;
    logic               issue;
    logic               pass_done;
    logic               out_free;
    logic               cand;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [CW:0]        mem_wdata;
    logic [CW:0]        mem_rdata;
    logic [CW-1:0]      rd_val;
    logic               rd_served;
    logic [CW-1:0]      alu_b;
    logic [CW-1:0]      alu_dist;
    t_alu_res           alu_res;

    assign in_xfer   = i_valid && !o_stall;
    assign cyl       = i_cylinder[CW-1:0];
    assign rd_val    = mem_rdata[CW-1:0];
    assign rd_served = mem_rdata[CW];
    assign issue     = ((r_state == S_FCFS) || (r_state == S_SCANP)) && (r_idx < r_cnt);
    assign pass_done = (r_idx == r_cnt) && !r_rdv;
    assign out_free  = !r_ovalid || !i_stall;

    // Ports.
    assign o_stall          = (r_state != S_LOAD);
    assign o_valid          = r_ovalid;
    assign o_total_movement = r_out_total;
    assign o_overflow       = r_out_ovf;

    // Request store write: requests while loading, served marks while computing.
    always_comb begin
        if (r_state == S_MARK) begin
            mem_we    = r_found;
            mem_waddr = r_bestidx;
            mem_wdata = {1'b1, r_bestval};
        end else begin
            mem_we    = in_xfer && r_head_ld && (r_cnt < CNT_MAX);
            mem_waddr = r_cnt[AW-1:0];
            mem_wdata = {1'b0, cyl};
        end
    end

    dss_mem #(
        .DEPTH (MAX_REQUESTS),
        .AW    (AW),
        .DW    (CW + 1)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Second operand of the distance unit: a stored request, the chosen one, or zero.
    always_comb begin
        if (r_state == S_MARK) begin
            alu_b = r_bestval;
        end else if (r_state == S_ZERO) begin
            alu_b = '0;
        end else begin
            alu_b = rd_val;
        end
    end

    dss_alu #(
        .CW (CW)
    ) u_alu (
        .i_a     (r_pos),
        .i_b     (alu_b),
        .i_best  (r_bestd),
        .i_total (r_total),
        .o_dist  (alu_dist),
        .o_res   (alu_res)
    );

    // A stored request is a candidate when unserved and inside the window.
    always_comb begin
        unique case (r_win)
            WIN_ALL:     cand = !rd_served;
            WIN_BELOW:   cand = !rd_served && (rd_val < r_head);
            WIN_ATLEAST: cand = !rd_served && (rd_val >= r_head);
            default:     cand = 1'b0;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (in_xfer && i_last_request) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = (r_run_pol == POL_FCFS) ? S_FCFS : S_SCANP;
            end
            S_FCFS: begin
                if (pass_done) begin
                    n_state = S_OUT;
                end
            end
            S_SCANP: begin
                if (pass_done) begin
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if (r_found) begin
                    n_state = S_SCANP;
                end else if ((r_run_pol == POL_SSTF) || r_step) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_ZERO;
                end
            end
            S_ZERO: begin
                n_state = S_SCANP;
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Datapath actions of each state.
    always_comb begin
        n_run_pol   = r_run_pol;
        n_win       = r_win;
        n_head      = r_head;
        n_head_ld   = r_head_ld;
        n_cnt       = r_cnt;
        n_drop      = r_drop;
        n_pos       = r_pos;
        n_total     = r_total;
        n_sat       = r_sat;
        n_idx       = issue ? CNTW'(r_idx + 1'b1) : r_idx;
        n_rdv       = issue;
        n_found     = r_found;
        n_bestd     = r_bestd;
        n_bestidx   = r_bestidx;
        n_bestval   = r_bestval;
        n_step      = r_step;
        n_ovalid    = r_ovalid && i_stall;
        n_out_total = r_out_total;
        n_out_ovf   = r_out_ovf;

        unique case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (!r_head_ld) begin
                        n_head    = cyl;
                        n_head_ld = 1'b1;
                    end else if (r_cnt < CNT_MAX) begin
                        n_cnt = CNTW'(r_cnt + 1'b1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_last_request) begin
                        n_run_pol = r_policy;
                    end
                end
            end
            S_PREP: begin
                n_pos   = r_head;
                n_total = '0;
                n_sat   = 1'b0;
                n_idx   = '0;
                n_found = 1'b0;
                n_step  = 1'b0;
                unique case (r_run_pol)
                    POL_SCAN:  n_win = WIN_BELOW;
                    POL_CSCAN: n_win = WIN_ATLEAST;
                    default:   n_win = WIN_ALL;
                endcase
            end
            S_FCFS: begin
                // Arrival order: every stored request is travelled to in turn.
                if (r_rdv) begin
                    n_total = alu_res.sum;
                    n_sat   = r_sat || alu_res.sat;
                    n_pos   = rd_val;
                end
            end
            S_SCANP: begin
                // Keep the nearest candidate; a strict compare keeps the earliest on a tie.
                if (r_rdv && cand && (!r_found || alu_res.lt)) begin
                    n_found   = 1'b1;
                    n_bestd   = alu_dist;
                    n_bestidx = r_ridx;
                    n_bestval = rd_val;
                end
            end
            S_MARK: begin
                if (r_found) begin
                    n_total = alu_res.sum;
                    n_sat   = r_sat || alu_res.sat;
                    n_pos   = r_bestval;
                    n_idx   = '0;
                    n_found = 1'b0;
                end
            end
            S_ZERO: begin
                // Travel to cylinder zero, then sweep the other side.
                n_total = alu_res.sum;
                n_sat   = r_sat || alu_res.sat;
                n_pos   = '0;
                n_step  = 1'b1;
                n_win   = (r_win == WIN_BELOW) ? WIN_ATLEAST : WIN_BELOW;
                n_idx   = '0;
                n_found = 1'b0;
            end
            S_OUT: begin
                if (out_free) begin
                    n_ovalid    = 1'b1;
                    n_out_total = r_total;
                    n_out_ovf   = r_drop || r_sat;
                    n_head      = '0;
                    n_head_ld   = 1'b0;
                    n_cnt       = '0;
                    n_drop      = 1'b0;
                end
            end
            default: begin
                n_ovalid = r_ovalid && i_stall;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_policy  <= POL_FCFS;
            r_run_pol <= POL_FCFS;
            r_win     <= WIN_ALL;
            r_head    <= '0;
            r_head_ld <= 1'b0;
            r_cnt     <= '0;
            r_drop    <= 1'b0;
            r_pos     <= '0;
            r_total   <= '0;
            r_sat     <= 1'b0;
            r_idx     <= '0;
            r_rdv     <= 1'b0;
            r_found   <= 1'b0;
            r_step    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_policy_we) begin
                r_policy <= t_policy'(i_policy);
            end
            r_run_pol <= n_run_pol;
            r_win     <= n_win;
            r_head    <= n_head;
            r_head_ld <= n_head_ld;
            r_cnt     <= n_cnt;
            r_drop    <= n_drop;
            r_pos     <= n_pos;
            r_total   <= n_total;
            r_sat     <= n_sat;
            r_idx     <= n_idx;
            r_rdv     <= n_rdv;
            r_found   <= n_found;
            r_step    <= n_step;
            r_ovalid  <= n_ovalid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_ridx      <= r_idx[AW-1:0];
        r_bestd     <= n_bestd;
        r_bestidx   <= n_bestidx;
        r_bestval   <= n_bestval;
        r_out_total <= n_out_total;
        r_out_ovf   <= n_out_ovf;
    end

endmodule

`default_nettype wire

// File: rtl/dss_checker.sv
// ----------------------------------------------------------------------------
// dss_checker: port-level checks of the disk seek distance calculator
// Tracks closed sets against delivered results and checks the result
// transfer and the stall after a closing item.
// ----------------------------------------------------------------------------
`default_nettype none

module dss_checker import dss_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_stall,
    input wire logic               i_last_request,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [TOTAL_W-1:0] o_total_movement,
    input wire logic               o_overflow
);

    logic [2:0] r_pend;
    logic       last_xfer;
    logic       out_xfer;

    assign last_xfer = i_valid && !o_stall && i_last_request;
    assign out_xfer  = o_valid && !i_stall;

    // Count closed sets whose result has not yet been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 3'(last_xfer) - 3'(out_xfer);
        end
    end

    // A waiting result holds its value until it is transferred.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_total_movement) && $stable(o_overflow)))
        else $error("result changed while stalled");

    // A result only appears for a closed set.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (r_pend != 3'd0))
        else $error("result without a closed set");

    // The input stalls once a closing item is taken.
    a_stall_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_xfer |=> o_stall)
        else $error("input not stalled during compute");

    // At most one set in compute and one result waiting.
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("too many sets outstanding");

endmodule

bind disk_seek_schedule_distance dss_checker u_dss_checker (.*);

`default_nettype wire

// File: verif/disk_seek_schedule_distance_tb.sv
// ----------------------------------------------------------------------------
// disk_seek_schedule_distance_tb: self-checking bench of the seek distance block
// Sends sets of a head position and cylinder requests under every policy,
// predicts the total head movement of each set and checks it against every
// result transfer. Both sides idle and stall at random, and the receiver is
// held off once long enough for the block to back up.
// ----------------------------------------------------------------------------

module disk_seek_schedule_distance_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import dss_pkg::*;

    localparam int REQ_DEPTH     = 64;
    localparam int CYL_TOP       = 65536;
    localparam int ITEM_GOAL     = 1550;
    localparam int SETTLE_CYCLES = 16;
    localparam int END_CYCLES    = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int SHOWN_ERRORS  = 10;

    // Expected contents of one result transfer.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               ovf;
    } t_movement;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_stall;
    logic [15:0]         i_cylinder     = '0;
    logic                i_last_request = 1'b0;
    logic                o_valid;
    logic                i_stall        = 1'b0;
    logic [TOTAL_W-1:0]  o_total_movement;
    logic                o_overflow;
    logic                i_policy_we    = 1'b0;
    logic [POLICY_W-1:0] i_policy       = '0;

    // Predictor state: the set being loaded and the walk in progress.
    logic [15:0] req_cyl  [REQ_DEPTH];
    bit          req_done [REQ_DEPTH];
    int          req_cnt;
    int          head_cyl;
    bit          head_seen;
    bit          req_dropped;
    int          walk_total;
    bit          walk_sat;
    t_policy     pol_model;

    t_movement   movement_q[$];

    // Run bookkeeping.
    int          err_count;
    int          results_seen;
    int          items_sent;
    int          sets_closed;
    int          pol_sets [4];
    bit          tx_calm;
    bit          rx_calm;
    int unsigned rx_hold_req;

    disk_seek_schedule_distance i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cylinder       (i_cylinder),
        .i_last_request   (i_last_request),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_total_movement (o_total_movement),
        .o_overflow       (o_overflow),
        .i_policy_we      (i_policy_we),
        .i_policy         (i_policy)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    function automatic int seek_dist(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Adds one seek to the walk, holding the total at its ceiling.
    function automatic void add_seek(int d);
        if (walk_total + d > int'(TOTAL_MAX)) begin
            walk_total = int'(TOTAL_MAX);
            walk_sat   = 1'b1;
        end else begin
            walk_total += d;
        end
    endfunction

    // Serves, nearest first, every unserved request in [lo, hi) starting at
    // pos; a tie goes to the earliest loaded request. Returns the end position.
    function automatic int serve_nearest_in(int pos, int lo, int hi);
        int best;
        int best_d;
        int v;
        bit found;
        do begin
            found  = 1'b0;
            best   = 0;
            best_d = 0;
            for (int i = 0; i < req_cnt; i++) begin
                v = req_cyl[i];
                if (!req_done[i] && v >= lo && v < hi &&
                    (!found || seek_dist(pos, v) < best_d)) begin
                    found  = 1'b1;
                    best   = i;
                    best_d = seek_dist(pos, v);
                end
            end
            if (found) begin
                req_done[best] = 1'b1;
                add_seek(best_d);
                pos = req_cyl[best];
            end
        end while (found);
        return pos;
    endfunction

    // Walks the closed set under the current policy.
    function automatic t_movement predict_movement();
        int        pos;
        t_movement res;
        walk_total = 0;
        walk_sat   = 1'b0;
        pos        = head_cyl;
        case (pol_model)
            POL_FCFS: begin
                for (int i = 0; i < req_cnt; i++) begin
                    add_seek(seek_dist(pos, req_cyl[i]));
                    pos = req_cyl[i];
                end
            end
            POL_SSTF: begin
                pos = serve_nearest_in(pos, 0, CYL_TOP);
            end
            POL_SCAN: begin
                pos = serve_nearest_in(pos, 0, head_cyl);
                add_seek(pos);
                pos = serve_nearest_in(0, head_cyl, CYL_TOP);
            end
            default: begin
                pos = serve_nearest_in(pos, head_cyl, CYL_TOP);
                add_seek(pos);
                pos = serve_nearest_in(0, 0, head_cyl);
            end
        endcase
        res.total = walk_total[TOTAL_W-1:0];
        res.ovf   = req_dropped || walk_sat;
        return res;
    endfunction

    // Takes in one accepted item; a closing item queues its expected result.
    function automatic void absorb_item(logic [15:0] cyl, logic last);
        if (!head_seen) begin
            head_cyl  = cyl;
            head_seen = 1'b1;
        end else if (req_cnt < REQ_DEPTH) begin
            req_cyl[req_cnt] = cyl;
            req_cnt++;
        end else begin
            req_dropped = 1'b1;
        end
        if (last) begin
            movement_q.push_back(predict_movement());
            pol_sets[int'(pol_model)]++;
            sets_closed++;
            req_cnt     = 0;
            head_cyl    = 0;
            head_seen   = 1'b0;
            req_dropped = 1'b0;
            foreach (req_done[i]) req_done[i] = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request cylinder, weighted towards the extremes, the head itself and
    // near neighbours of the head so that equal distances turn up.
    function automatic logic [15:0] pick_cylinder(logic [15:0] head);
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return head;
            3, 4, 5: return head + 16'($urandom_range(0, 64)) - 16'd32;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Offers one item and waits for its transfer. Stall is looked at on the
    // falling edge, where it is steady up to the next rising edge.
    task automatic send_item(input logic [15:0] cyl, input logic last);
        int unsigned gap;
        bit          taken;
        gap = tx_calm ? 0 : pick_gap();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cylinder     <= cyl;
        i_last_request <= last;
        do begin
            @(negedge i_clk);
            taken = (o_stall === 1'b0);
            @(posedge i_clk);
        end while (!taken);
        absorb_item(cyl, last);
        items_sent++;
    endtask

    // Sends a head position followed by n_req requests, the last one closing.
    task automatic send_set(input int n_req);
        logic [15:0] head;
        case ($urandom_range(0, 7))
            0:       head = 16'h0000;
            1:       head = 16'hFFFF;
            default: head = 16'($urandom_range(0, 65535));
        endcase
        send_item(head, n_req == 0);
        for (int i = 1; i <= n_req; i++) begin
            send_item(pick_cylinder(head), i == n_req);
        end
    endtask

    // Stops offering and waits until every expected result has arrived.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (movement_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes the policy register; only called with the block idle.
    task automatic set_policy(input t_policy p);
        i_policy_we <= 1'b1;
        i_policy    <= p;
        @(posedge i_clk);
        i_policy_we <= 1'b0;
        pol_model = p;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Extreme cylinders, a request equal to the head and an equal-distance
    // pair, under each policy, each followed by a set of the head alone.
    task automatic test_policy_edges();
        logic [15:0] lone_head [4];
        lone_head = '{16'h1234, 16'h0000, 16'hFFFF, 16'h8001};
        for (int p = 0; p < 4; p++) begin
            wait_idle();
            set_policy(t_policy'(p));
            send_item(16'h8000, 1'b0);
            send_item(16'h8010, 1'b0);
            send_item(16'h7FF0, 1'b0);
            send_item(16'hFFFF, 1'b0);
            send_item(16'h0000, 1'b0);
            send_item(16'h8000, 1'b1);
            send_item(lone_head[p], 1'b1);
        end
    endtask

    // Sets that fill the request store exactly, and ones that overrun it so
    // that later requests, the closing one included, are dropped.
    task automatic test_capacity();
        wait_idle();
        set_policy(POL_SSTF);
        send_set(REQ_DEPTH + 2);
        wait_idle();
        set_policy(POL_FCFS);
        send_set(REQ_DEPTH);
        wait_idle();
        set_policy(POL_CSCAN);
        send_set(REQ_DEPTH + 1);
        send_set(REQ_DEPTH);
    endtask

    // Receiver held off for a long stretch while the sender keeps offering
    // sets back to back, so the block backs up and stalls its input.
    task automatic test_backpressure();
        wait_idle();
        set_policy(POL_SCAN);
        tx_calm     = 1'b1;
        rx_hold_req = HOLD_CYCLES;
        for (int s = 0; s < 6; s++) begin
            send_set(3);
        end
        tx_calm = 1'b0;
        wait_idle();
    endtask

    // Random sets in batches, each batch under a random policy. Most sets are
    // short; a few run from just under to past the capacity of the store.
    task automatic test_random_sets();
        int n_sets;
        int n_req;
        while (items_sent < ITEM_GOAL) begin
            wait_idle();
            set_policy(t_policy'($urandom_range(0, 3)));
            tx_calm = ($urandom_range(0, 4) == 0);
            rx_calm = ($urandom_range(0, 4) == 0);
            n_sets  = $urandom_range(1, 8);
            for (int s = 0; s < n_sets; s++) begin
                if ($urandom_range(0, 39) == 0) n_req = $urandom_range(60, 70);
                else                            n_req = $urandom_range(0, 10);
                send_set(n_req);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off counted here on request.
    // ------------------------------------------------------------------------
    initial begin : rx_side
        int unsigned busy;
        busy = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req != 0) begin
                busy        = rx_hold_req;
                rx_hold_req = 0;
            end else if (busy == 0 && !rx_calm && $urandom_range(0, 2) == 0) begin
                busy = pick_gap();
            end
            if (busy != 0) begin
                i_stall <= 1'b1;
                busy--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: a transfer happens at the next rising edge when valid is
    // high and stall is low on the falling edge before it.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : result_check
        t_movement want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (movement_q.size() == 0) begin
                err_count++;
                if (err_count <= SHOWN_ERRORS)
                    $display("ERROR: result with none expected: total=%0d overflow=%0b",
                             o_total_movement, o_overflow);
            end else begin
                want = movement_q.pop_front();
                results_seen++;
                if (o_total_movement !== want.total || o_overflow !== want.ovf) begin
                    err_count++;
                    if (err_count <= SHOWN_ERRORS)
                        $display("ERROR: result %0d: total exp %0d got %0d, overflow exp %0b got %0b",
                                 results_seen, want.total, o_total_movement,
                                 want.ovf, o_overflow);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial begin : main_seq
        req_cnt      = 0;
        head_cyl     = 0;
        head_seen    = 1'b0;
        req_dropped  = 1'b0;
        pol_model    = POL_FCFS;
        err_count    = 0;
        results_seen = 0;
        items_sent   = 0;
        sets_closed  = 0;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        rx_hold_req  = 0;
        foreach (req_done[i]) req_done[i] = 1'b0;
        foreach (pol_sets[i]) pol_sets[i] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_policy_edges();
        test_capacity();
        test_backpressure();
        test_random_sets();

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);

        $display("Summary: %0d items in %0d sets, %0d results checked, %0d mismatches.",
                 items_sent, sets_closed, results_seen, err_count);
        $display("Sets per policy: FCFS %0d, SSTF %0d, SCAN %0d, C-SCAN %0d.",
                 pol_sets[0], pol_sets[1], pol_sets[2], pol_sets[3]);
        if (err_count == 0 && movement_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #20_000_000;
        $display("Timeout with %0d results still expected.", movement_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: disk_seek_schedule_distance.f
rtl/dss_pkg.sv
rtl/dss_mem.sv
rtl/dss_alu.sv
rtl/disk_seek_schedule_distance.sv
rtl/dss_checker.sv
verif/disk_seek_schedule_distance_tb.sv
